FILE: design/bpti_pkg.sv
`default_nettype none
package bpti_pkg;
	localparam int FreqW = 32;
	localparam int AmpW  = 32;
	localparam int MagW  = 33;
	localparam int SumW  = 48;
	localparam int ProdW = 65;
	localparam int DivCntW = 7;
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

	localparam logic CfgBandLow  = 1'b0;
	localparam logic CfgBandHigh = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_L,
		ST_DIV_L,
		ST_MUL_R,
		ST_DIV_R,
		ST_AREA1,
		ST_AREA2,
		ST_ACC,
		ST_DONE,
		ST_OUT
	} bpti_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic check;
		logic mul_left;
		logic mul_right;
		logic div_start;
		logic div_step;
		logic edge_left;
		logic edge_right;
		logic area1;
		logic area2;
		logic accumulate;
		logic finish;
		logic out_take;
	} bpti_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic have_prev;
		logic area_zero;
		logic div_done;
		logic last;
	} bpti_stat_t;
endpackage
`default_nettype wire

FILE: design/bpti_ctrl.sv
`default_nettype none
module bpti_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  bpti_pkg::bpti_stat_t stat,
	output bpti_pkg::bpti_cmd_t  cmd
);
	import bpti_pkg::*;

	bpti_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CHECK;
			ST_CHECK: state_d = (!stat.have_prev || stat.area_zero) ? ST_DONE : ST_MUL_L;
			ST_MUL_L: state_d = ST_DIV_L;
			ST_DIV_L: if (stat.div_done) state_d = ST_MUL_R;
			ST_MUL_R: state_d = ST_DIV_R;
			ST_DIV_R: if (stat.div_done) state_d = ST_AREA1;
			ST_AREA1: state_d = ST_AREA2;
			ST_AREA2: state_d = ST_ACC;
			ST_ACC:   state_d = ST_DONE;
			ST_DONE:  state_d = stat.last ? ST_OUT : ST_IDLE;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CHECK: cmd.check = 1'b1;
			ST_MUL_L: begin
				cmd.mul_left = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIV_L: begin
				cmd.div_step = 1'b1;
				cmd.edge_left = stat.div_done;
			end
			ST_MUL_R: begin
				cmd.mul_right = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIV_R: begin
				cmd.div_step = 1'b1;
				cmd.edge_right = stat.div_done;
			end
			ST_AREA1: cmd.area1 = 1'b1;
			ST_AREA2: cmd.area2 = 1'b1;
			ST_ACC:   cmd.accumulate = 1'b1;
			ST_DONE:  cmd.finish = 1'b1;
			ST_OUT: begin
				out_valid = 1'b1;
				cmd.out_take = out_ready;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: design/bpti_datapath.sv
`default_nettype none
module bpti_datapath (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire                        cfg_index,
	input  wire  [bpti_pkg::FreqW-1:0] cfg_data,
	input  wire  [bpti_pkg::FreqW-1:0] point_frequency,
	input  wire  signed [bpti_pkg::AmpW-1:0] point_amplitude,
	input  wire                        last_point,
	input  bpti_pkg::bpti_cmd_t        cmd,
	output bpti_pkg::bpti_stat_t       stat,
	output logic [bpti_pkg::SumW-1:0]  band_power,
	output logic                       overflowed
);
	import bpti_pkg::*;

	logic [FreqW-1:0] band_low_q, band_high_q;
	logic [FreqW-1:0] prev_f_q, cur_f_q, fl_q, fr_q;
	logic [MagW-1:0]  prev_m_q, cur_m_q, al_q, ar_q;
	logic             have_prev_q, last_q, rise_q;
	logic [SumW-1:0]  sum_q;
	logic             sat_q;
	logic [ProdW-1:0] num_q;
	logic [FreqW:0]   rem_q;
	logic [FreqW-1:0] w0_q;
	logic [DivCntW-1:0] cnt_q;
	logic [ProdW-1:0] area_a_q, area_b_q, area_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_low_q  <= '0;
			band_high_q <= '1;
		end else if (cfg_we) begin
			if (cfg_index == CfgBandLow) band_low_q  <= cfg_data;
			else                         band_high_q <= cfg_data;
		end
	end

	// magnitude of the incoming amplitude, 2^31 fits in 33 bits
	logic [MagW-1:0] mag_in;
	assign mag_in = point_amplitude[AmpW-1] ?
		(MagW'(0) - MagW'(point_amplitude)) & {1'b0, {(MagW-1){1'b1}}} :
		MagW'(point_amplitude);

	// clipping
	logic [FreqW-1:0] fl_c, fr_c;
	logic             zero_c;
	assign fl_c = (band_low_q > prev_f_q) ? band_low_q : prev_f_q;
	assign fr_c = (band_high_q < cur_f_q) ? band_high_q : cur_f_q;
	assign zero_c = (band_low_q >= band_high_q) || (cur_f_q <= prev_f_q) ||
		(cur_f_q <= band_low_q) || (fr_c <= fl_c);

	logic [MagW-1:0] d_mag;
	assign d_mag = rise_q ? cur_m_q - prev_m_q : prev_m_q - cur_m_q;

	// restoring divider step
	logic [FreqW+1:0] trial;
	assign trial = {rem_q, num_q[ProdW-1]} - {2'b0, w0_q};

	logic [MagW-1:0] q_edge;
	assign q_edge = num_q[MagW-1:0];
	logic [MagW-1:0] edge_amp;
	assign edge_amp = rise_q ? prev_m_q + q_edge : prev_m_q - q_edge;

	logic [FreqW-1:0] w_c;
	assign w_c = fr_q - fl_q;
	logic [MagW-1:0] mn_c, dd_c;
	assign mn_c = (al_q < ar_q) ? al_q : ar_q;
	assign dd_c = (al_q < ar_q) ? ar_q - al_q : al_q - ar_q;

	logic [SumW:0] add_c;
	assign add_c = {1'b0, sum_q} + {1'b0, area_q[SumW-1:0]};
	logic area_big;
	assign area_big = |area_q[ProdW-1:SumW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			sum_q <= '0;
			sat_q <= 1'b0;
			cnt_q <= '0;
			last_q <= 1'b0;
			prev_f_q <= '0;
			prev_m_q <= '0;
			cur_f_q <= '0;
			cur_m_q <= '0;
			fl_q <= '0;
			fr_q <= '0;
			al_q <= '0;
			ar_q <= '0;
			rise_q <= 1'b0;
			w0_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			area_a_q <= '0;
			area_b_q <= '0;
			area_q <= '0;
		end else begin
			if (cmd.load) begin
				cur_f_q <= point_frequency;
				cur_m_q <= mag_in;
				last_q  <= last_point;
			end
			if (cmd.check) begin
				fl_q <= fl_c;
				fr_q <= fr_c;
				rise_q <= cur_m_q >= prev_m_q;
				w0_q <= cur_f_q - prev_f_q;
			end
			// multiply offset by amplitude step, then divide by width
			if (cmd.mul_left)
				num_q <= ProdW'(fl_q - prev_f_q) * ProdW'(d_mag);
			if (cmd.mul_right)
				num_q <= ProdW'(fr_q - prev_f_q) * ProdW'(d_mag);
			if (cmd.div_start) begin
				rem_q <= '0;
				cnt_q <= '0;
			end else if (cmd.div_step && cnt_q != DivCntW'(ProdW)) begin
				cnt_q <= cnt_q + 1'b1;
				if (!trial[FreqW+1]) begin
					rem_q <= trial[FreqW:0];
					num_q <= {num_q[ProdW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[FreqW-1:0], num_q[ProdW-1]};
					num_q <= {num_q[ProdW-2:0], 1'b0};
				end
			end
			if (cmd.edge_left)  al_q <= edge_amp;
			if (cmd.edge_right) ar_q <= edge_amp;
			// trapezoid area
			if (cmd.area1) begin
				area_a_q <= ProdW'(mn_c) * ProdW'(w_c);
				area_b_q <= ProdW'(dd_c) * ProdW'(w_c);
			end
			if (cmd.area2)
				area_q <= (area_a_q + (area_b_q >> 1)) >> 16;
			if (cmd.accumulate) begin
				if (area_big || add_c[SumW]) begin
					sum_q <= SumMax;
					sat_q <= 1'b1;
				end else begin
					sum_q <= add_c[SumW-1:0];
				end
			end
			if (cmd.finish && !last_q) begin
				prev_f_q <= cur_f_q;
				prev_m_q <= cur_m_q;
				have_prev_q <= 1'b1;
			end
			if (cmd.out_take) begin
				prev_f_q <= '0;
				prev_m_q <= '0;
				have_prev_q <= 1'b0;
				sum_q <= '0;
				sat_q <= 1'b0;
			end
		end
	end

	assign stat.have_prev = have_prev_q;
	assign stat.area_zero = zero_c;
	assign stat.div_done  = cnt_q == DivCntW'(ProdW);
	assign stat.last      = last_q;
	assign band_power = sum_q;
	assign overflowed = sat_q;
endmodule
`default_nettype wire

FILE: design/band_power_trapezoid_integrator_unit.sv
`default_nettype none
// channel   | handshake             | payload
// point in  | in_valid / in_ready   | point_frequency, point_amplitude, last_point
// result    | out_valid / out_ready | band_power, overflowed
// config    | cfg_we                | cfg_index, cfg_data
// An interval inside the band spends most of its time in two serial 65-step
// divisions by the interval width. Skipped intervals go from the check state
// straight to done. A last point also passes through the output state, which stalls on out_ready.
// Reset sets the band to the full range and clears the running sum.
// A result waits in its register until taken; the next point is held meanwhile.
module band_power_trapezoid_integrator_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [31:0] point_frequency,
	input  wire  signed [31:0] point_amplitude,
	input  wire         last_point,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [47:0] band_power,
	output logic        overflowed
);
	import bpti_pkg::*;

	bpti_cmd_t  cmd;
	bpti_stat_t stat;

	bpti_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	bpti_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .point_frequency(point_frequency),
		.point_amplitude(point_amplitude), .last_point(last_point),
		.cmd(cmd), .stat(stat), .band_power(band_power), .overflowed(overflowed)
	);

	// never ready for a request while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// saturation pins the sum at full scale
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		overflowed |-> band_power == SumMax) else $error("saturated sum not full");
	// taking a result clears the sum
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> band_power == '0 && !overflowed)
		else $error("sum not cleared");
endmodule
`default_nettype wire
